[rtl/imc_pkg.sv]
// Package with the types, codes and constants of the im2col/col2im engine.
`timescale 1ns / 1ps
package imc_pkg;

  localparam int PLANES_DEF     = 4;
  localparam int IMG_DIM_DEF    = 32;
  localparam int MAX_KERNEL_DEF = 7;

  localparam int ADDR_MAX_W = 22;
  localparam int CFG_W      = 6;
  localparam int CFG_IDX_W  = 4;
  localparam int DIV_W      = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_KERN_ROWS    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERN_COLS    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_ROWS    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COLS    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_ROWS  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_COLS  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 4'd7;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_FETCH = 2'd2,
    ACT_ACC   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PAD   = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_ACC   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         plane;
    logic [4:0]         pixel_row;
    logic [4:0]         pixel_col;
    logic [7:0]         column_row;
    logic [11:0]        column_pos;
    logic signed [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
  } out_rsp_t;

  typedef struct packed {
    logic [2:0] kern_rows;
    logic [2:0] kern_cols;
    logic [3:0] step_rows;
    logic [3:0] step_cols;
    logic [2:0] margin_rows;
    logic [2:0] margin_cols;
    logic [5:0] image_height;
    logic [5:0] image_width;
  } cfg_t;

  typedef struct packed {
    op_e                   op;
    logic [ADDR_MAX_W-1:0] addr;
    logic [31:0]           value;
    logic [1:0]            status;
  } op_t;

endpackage

[rtl/imc_chan_if.sv]
// Valid/ready channel interface carrying one payload of a parameter type.
`timescale 1ns / 1ps
interface imc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/imc_fifo.sv]
// Two-entry queue between the classifying front and the memory back end.
`timescale 1ns / 1ps
module imc_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);
  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end
endmodule

[rtl/imc_front.sv]
// Front end: accepts requests, decodes column coordinates and forms store operations.
`timescale 1ns / 1ps
module imc_front #(
  parameter int PLANES     = imc_pkg::PLANES_DEF,
  parameter int IMG_DIM    = imc_pkg::IMG_DIM_DEF,
  parameter int MAX_KERNEL = imc_pkg::MAX_KERNEL_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  imc_pkg::cfg_t cfg_i,
  input  logic          enable_i,
  imc_chan_if.sink      req_i,
  output logic          op_valid_o,
  output imc_pkg::op_t  op_o,
  input  logic          op_ready_i
);
  import imc_pkg::*;

  typedef enum logic [8:0] {
    F_IDLE     = 9'b000000001,
    F_CLASSIFY = 9'b000000010,
    F_DIV_OW   = 9'b000000100,
    F_DIV_OH   = 9'b000001000,
    F_DIV_P    = 9'b000010000,
    F_DIV_KR   = 9'b000100000,
    F_DIV_Y    = 9'b001000000,
    F_CALC     = 9'b010000000,
    F_PUSH     = 9'b100000000
  } fstate_e;

  fstate_e          state_q;
  in_req_t          req_q;
  op_t              op_q;
  logic [6:0]       ow_q, oh_q;
  logic [7:0]       p_q;
  logic [2:0]       kr_q, kc_q;
  logic [DIV_W-1:0] dnum_q, dquo_q;
  logic [7:0]       dden_q;
  logic [DIV_W:0]   drem_q;
  logic [3:0]       dcnt_q;

  logic [DIV_W:0]   rem_sh, rem_nx;
  logic             take;
  logic             usable;
  logic [7:0]       padded_h, padded_w;
  logic [5:0]       area;
  logic             pix_ok;
  logic [31:0]      pix_addr, col_addr;
  logic [13:0]      num_pos;
  logic [10:0]      ymul, xmul;
  logic signed [13:0] iy, ix;
  logic             in_pad;
  action_e          act;

  assign act = action_e'(req_q.action);

  assign rem_sh = {drem_q[DIV_W-1:0], dnum_q[DIV_W-1]};
  assign take   = rem_sh >= {5'd0, dden_q};
  assign rem_nx = take ? rem_sh - {5'd0, dden_q} : rem_sh;

  assign usable = cfg_i.kern_rows != 3'd0 && 32'(cfg_i.kern_rows) <= MAX_KERNEL &&
                  cfg_i.kern_cols != 3'd0 && 32'(cfg_i.kern_cols) <= MAX_KERNEL &&
                  cfg_i.step_rows != 4'd0 && cfg_i.step_cols != 4'd0 &&
                  cfg_i.image_height != 6'd0 && 32'(cfg_i.image_height) <= IMG_DIM &&
                  cfg_i.image_width != 6'd0 && 32'(cfg_i.image_width) <= IMG_DIM;

  assign padded_h = 8'(cfg_i.image_height) + {4'd0, cfg_i.margin_rows, 1'b0};
  assign padded_w = 8'(cfg_i.image_width) + {4'd0, cfg_i.margin_cols, 1'b0};
  assign area     = cfg_i.kern_rows * cfg_i.kern_cols;

  assign pix_ok   = 32'(req_q.plane) < PLANES &&
                    {1'b0, req_q.pixel_row} < cfg_i.image_height &&
                    {1'b0, req_q.pixel_col} < cfg_i.image_width;
  assign pix_addr = 32'(req_q.plane) * 32'(IMG_DIM * IMG_DIM) +
                    32'(req_q.pixel_row) * 32'(IMG_DIM) + 32'(req_q.pixel_col);

  assign num_pos = oh_q * ow_q;

  assign ymul   = dquo_q[6:0] * cfg_i.step_rows;
  assign xmul   = drem_q[6:0] * cfg_i.step_cols;
  assign iy     = $signed({3'd0, ymul}) + $signed({11'd0, kr_q}) -
                  $signed({11'd0, cfg_i.margin_rows});
  assign ix     = $signed({3'd0, xmul}) + $signed({11'd0, kc_q}) -
                  $signed({11'd0, cfg_i.margin_cols});
  assign in_pad = iy < 0 || iy >= $signed({8'd0, cfg_i.image_height}) ||
                  ix < 0 || ix >= $signed({8'd0, cfg_i.image_width});
  assign col_addr = 32'(p_q) * 32'(IMG_DIM * IMG_DIM) +
                    32'(iy[12:0]) * 32'(IMG_DIM) + 32'(ix[12:0]);

  assign req_i.ready = (state_q == F_IDLE) && enable_i;
  assign op_valid_o  = (state_q == F_PUSH);
  assign op_o        = op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      req_q   <= '0;
      op_q    <= '0;
      ow_q    <= '0;
      oh_q    <= '0;
      p_q     <= '0;
      kr_q    <= '0;
      kc_q    <= '0;
      dnum_q  <= '0;
      dden_q  <= '0;
      dquo_q  <= '0;
      drem_q  <= '0;
      dcnt_q  <= '0;
    end else begin
      if (dcnt_q != 4'd0) begin
        dnum_q <= {dnum_q[DIV_W-2:0], 1'b0};
        drem_q <= rem_nx;
        dquo_q <= {dquo_q[DIV_W-2:0], take};
        dcnt_q <= dcnt_q - 4'd1;
      end
      case (state_q)
        F_IDLE: begin
          if (req_i.valid && req_i.ready) begin
            req_q   <= req_i.payload;
            state_q <= F_CLASSIFY;
          end
        end
        F_CLASSIFY: begin
          op_q.value <= req_q.value;
          op_q.addr  <= pix_addr[ADDR_MAX_W-1:0];
          if (!usable) begin
            op_q.op     <= OP_NONE;
            op_q.status <= ST_RANGE;
            state_q     <= F_PUSH;
          end else if (act == ACT_WRITE || act == ACT_READ) begin
            if (pix_ok) begin
              op_q.op     <= (act == ACT_WRITE) ? OP_WRITE : OP_READ;
              op_q.status <= ST_OK;
            end else begin
              op_q.op     <= OP_NONE;
              op_q.status <= ST_RANGE;
            end
            state_q <= F_PUSH;
          end else if (padded_w < 8'(cfg_i.kern_cols) ||
                       padded_h < 8'(cfg_i.kern_rows)) begin
            op_q.op     <= OP_NONE;
            op_q.status <= ST_RANGE;
            state_q     <= F_PUSH;
          end else begin
            op_q.op     <= OP_NONE;
            op_q.status <= ST_RANGE;
            dnum_q      <= DIV_W'(padded_w - 8'(cfg_i.kern_cols));
            dden_q      <= {4'd0, cfg_i.step_cols};
            dquo_q      <= '0;
            drem_q      <= '0;
            dcnt_q      <= 4'(DIV_W);
            state_q     <= F_DIV_OW;
          end
        end
        F_DIV_OW: begin
          if (dcnt_q == 4'd0) begin
            ow_q    <= dquo_q[6:0] + 7'd1;
            dnum_q  <= DIV_W'(padded_h - 8'(cfg_i.kern_rows));
            dden_q  <= {4'd0, cfg_i.step_rows};
            dquo_q  <= '0;
            drem_q  <= '0;
            dcnt_q  <= 4'(DIV_W);
            state_q <= F_DIV_OH;
          end
        end
        F_DIV_OH: begin
          if (dcnt_q == 4'd0) begin
            oh_q    <= dquo_q[6:0] + 7'd1;
            dnum_q  <= {4'd0, req_q.column_row};
            dden_q  <= {2'd0, area};
            dquo_q  <= '0;
            drem_q  <= '0;
            dcnt_q  <= 4'(DIV_W);
            state_q <= F_DIV_P;
          end
        end
        F_DIV_P: begin
          if (dcnt_q == 4'd0) begin
            p_q     <= dquo_q[7:0];
            dnum_q  <= DIV_W'(drem_q[7:0]);
            dden_q  <= {5'd0, cfg_i.kern_cols};
            dquo_q  <= '0;
            drem_q  <= '0;
            dcnt_q  <= 4'(DIV_W);
            state_q <= F_DIV_KR;
          end
        end
        F_DIV_KR: begin
          if (dcnt_q == 4'd0) begin
            kr_q <= dquo_q[2:0];
            kc_q <= drem_q[2:0];
            if (32'(p_q) >= PLANES || {2'd0, req_q.column_pos} >= num_pos) begin
              state_q <= F_PUSH;
            end else begin
              dnum_q  <= req_q.column_pos;
              dden_q  <= {1'b0, ow_q};
              dquo_q  <= '0;
              drem_q  <= '0;
              dcnt_q  <= 4'(DIV_W);
              state_q <= F_DIV_Y;
            end
          end
        end
        F_DIV_Y: begin
          if (dcnt_q == 4'd0) begin
            state_q <= F_CALC;
          end
        end
        F_CALC: begin
          op_q.addr <= col_addr[ADDR_MAX_W-1:0];
          if (in_pad) begin
            op_q.status <= ST_PAD;
          end else begin
            op_q.status <= ST_OK;
            op_q.op     <= (act == ACT_FETCH) ? OP_READ : OP_ACC;
          end
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (op_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end
endmodule

[rtl/imc_back.sv]
// Back end: image store, clearing pass, read and read-modify-write, result register.
`timescale 1ns / 1ps
module imc_back #(
  parameter int PLANES  = imc_pkg::PLANES_DEF,
  parameter int IMG_DIM = imc_pkg::IMG_DIM_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         op_valid_i,
  input  imc_pkg::op_t op_i,
  output logic         op_pop_o,
  output logic         clear_done_o,
  imc_chan_if.source   rsp_o
);
  import imc_pkg::*;

  localparam int DEPTH = PLANES * IMG_DIM * IMG_DIM;
  localparam int AW    = $clog2(DEPTH);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;
  logic [AW:0] clr_cnt_q;
  logic        clearing;
  op_t         s1_q;
  logic        s1_v_q;
  out_rsp_t    out_q;
  logic        out_v_q;
  logic        pop;
  logic        we;
  logic [AW-1:0] waddr;
  logic [31:0] wdata;

  assign clearing     = !clr_cnt_q[AW];
  assign clear_done_o = !clearing;
  assign pop          = op_valid_i && !clearing && !s1_v_q && (!out_v_q || rsp_o.ready);
  assign op_pop_o     = pop;

  assign we    = clearing || (s1_v_q && (s1_q.op == OP_WRITE || s1_q.op == OP_ACC));
  assign waddr = clearing ? clr_cnt_q[AW-1:0] : s1_q.addr[AW-1:0];
  assign wdata = clearing ? 32'd0 :
                 (s1_q.op == OP_ACC) ? rdata_q + s1_q.value : s1_q.value;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[op_i.addr[AW-1:0]];
  end

  assign rsp_o.valid   = out_v_q;
  assign rsp_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      s1_v_q    <= 1'b0;
      s1_q      <= '0;
      out_v_q   <= 1'b0;
      out_q     <= '0;
    end else begin
      if (clearing) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (out_v_q && rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
      s1_v_q <= pop;
      if (pop) begin
        s1_q <= op_i;
      end
      if (s1_v_q) begin
        out_v_q      <= 1'b1;
        out_q.status <= s1_q.status;
        out_q.data   <= (s1_q.op == OP_READ) ? rdata_q : 32'd0;
      end
    end
  end
endmodule

[rtl/im2col_col2im_engine.sv]
// Top level of the im2col/col2im engine: configuration registers, front, queue and back.
//
//   channel  dir  payload                                                   handshake
//   req_i    in   action plane pixel_row pixel_col column_row column_pos value  valid/ready
//   rsp_o    out  data status                                                valid/ready
//   cfg      in   cfg_idx_i cfg_wdata_i                                      cfg_we_i
//
// A pixel request passes the classify and push states before the next one is accepted;
// the push state waits for room in the queue. A column request occupies the front for
// the classify state, five serial divisions on the one shared divider, the address state
// and the push state. Out-of-range requests and unusable registers finish earlier.
// The back end takes a store operation (read, then write back) once the previous one
// has left the read stage and the result register is free or being taken. After reset
// a clearing pass zeroes the PLANES*IMG_DIM*IMG_DIM store words (4096 by default),
// during which no request is accepted.
// The queue lets the front decode the next request while a result waits on rsp_o.
`timescale 1ns / 1ps
module im2col_col2im_engine #(
  parameter int PLANES     = imc_pkg::PLANES_DEF,
  parameter int IMG_DIM    = imc_pkg::IMG_DIM_DEF,
  parameter int MAX_KERNEL = imc_pkg::MAX_KERNEL_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [imc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [imc_pkg::CFG_W-1:0]       cfg_wdata_i,
  imc_chan_if.sink                        req_i,
  imc_chan_if.source                      rsp_o
);
  import imc_pkg::*;

  cfg_t  cfg_q;
  logic  clear_done;
  logic  op_valid, op_ready, q_full, q_empty, q_pop;
  op_t   op_front, op_back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kern_rows    <= 3'd3;
      cfg_q.kern_cols    <= 3'd3;
      cfg_q.step_rows    <= 4'd1;
      cfg_q.step_cols    <= 4'd1;
      cfg_q.margin_rows  <= 3'd0;
      cfg_q.margin_cols  <= 3'd0;
      cfg_q.image_height <= 6'd32;
      cfg_q.image_width  <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KERN_ROWS:    cfg_q.kern_rows    <= cfg_wdata_i[2:0];
        CFG_KERN_COLS:    cfg_q.kern_cols    <= cfg_wdata_i[2:0];
        CFG_STEP_ROWS:    cfg_q.step_rows    <= cfg_wdata_i[3:0];
        CFG_STEP_COLS:    cfg_q.step_cols    <= cfg_wdata_i[3:0];
        CFG_MARGIN_ROWS:  cfg_q.margin_rows  <= cfg_wdata_i[2:0];
        CFG_MARGIN_COLS:  cfg_q.margin_cols  <= cfg_wdata_i[2:0];
        CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_wdata_i;
        CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  imc_front #(
    .PLANES     (PLANES),
    .IMG_DIM    (IMG_DIM),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .enable_i   (clear_done),
    .req_i      (req_i),
    .op_valid_o (op_valid),
    .op_o       (op_front),
    .op_ready_i (op_ready)
  );

  assign op_ready = !q_full;

  imc_fifo #(
    .W ($bits(op_t))
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_valid),
    .wdata_i (op_front),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (op_back),
    .empty_o (q_empty)
  );

  imc_back #(
    .PLANES  (PLANES),
    .IMG_DIM (IMG_DIM)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (!q_empty),
    .op_i         (op_back),
    .op_pop_o     (q_pop),
    .clear_done_o (clear_done),
    .rsp_o        (rsp_o)
  );
endmodule
